// ===== rtl/signed_integer_to_radix_text_assert.svh =====
// Assertion macros shared by the radix text converter RTL.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SITRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SITRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sitrt_pkg.sv =====
// Shared types, constants and helpers for the radix text converter.
// Used by sitrt_ctrl, sitrt_dp and signed_integer_to_radix_text; no dependencies.
package sitrt_pkg;

  localparam int VALUE_BITS_DEF  = 32;
  localparam int DIGIT_SLOTS_DEF = 33;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;  // 'A'

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PUSH,
    S_SIGN,
    S_POP_RD,
    S_POP_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture value, magnitude and radix
    logic div_step;    // one restoring division step
    logic push_digit;  // push glyph of remainder, start next digit
    logic push_sign;   // push '-'
    logic pop_rd;      // read top of stack
    logic out_load;    // move read data into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;    // current step is the last of this digit
    logic mag_zero;    // quotient is zero
    logic neg;         // value was negative
    logic rd_last;     // read data is the final character
    logic slot_free;   // output register can take an item
    logic fill_zero;   // stack is empty
  } status_t;

  // digit 0..35 to ASCII glyph
  function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DEC_DIGITS) begin
      glyph = CHAR_ZERO + d_ext;
    end else begin
      glyph = CHAR_A + d_ext - {1'b0, DEC_DIGITS};
    end
  endfunction

endpackage

// ===== rtl/signed_integer_to_radix_text.sv =====
// Signed integer to radix text. Each input item is a two's complement integer;
// the block returns its text in the radix held in the cfg register (2..36,
// values outside saturate), one ASCII character per output item, most
// significant first, with a leading '-' for negatives and tlast on the final
// character. One item is handled at a time. Each digit comes from a bit-serial
// restoring division of the magnitude by the radix, followed by a stack push; a
// negative value then has its '-' pushed, and each character is read out of the
// stack memory's registered read port into the output register.
// A new item is taken while the last character still waits in the output register.
`include "signed_integer_to_radix_text_assert.svh"

module signed_integer_to_radix_text #(
  parameter int VALUE_BITS  = sitrt_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_SLOTS = sitrt_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wen,
  input  logic [sitrt_pkg::RADIX_W-1:0]     cfg_wdata,  // radix
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   in_tdata,   // value
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // text_char, zero pad
  output logic                              out_tlast   // last_char
);
  import sitrt_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [CHAR_W-1:0] out_char;

  sitrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sitrt_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .value     (in_tdata[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  // checks
  `SITRT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted while converting")
  `SITRT_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_tvalid || out_tready, "pending item overwritten")
  `SITRT_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop_rd, !status.fill_zero, "pop from empty digit stack")

endmodule

// ===== rtl/sitrt_ctrl.sv =====
// Sequencer for the radix text converter: division loop, stack pushes, pops.
// Depends on sitrt_pkg for the state, command and status types.
module sitrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sitrt_pkg::status_t status,
  output sitrt_pkg::cmd_t    cmd
);
  import sitrt_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_digit = 1'b1;
        if (!status.mag_zero) begin
          state_nxt = S_DIV;
        end else if (status.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_SIGN: begin
        cmd.push_sign = 1'b1;
        state_nxt     = S_POP_RD;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.rd_last ? S_IDLE : S_POP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/sitrt_dp.sv =====
// Datapath of the radix text converter: radix register, bit-serial divider,
// digit stack memory and output register. Depends on sitrt_pkg.
module sitrt_dp #(
  parameter int VALUE_BITS  = sitrt_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_SLOTS = sitrt_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [sitrt_pkg::RADIX_W-1:0]   cfg_wdata,
  input  logic [VALUE_BITS-1:0]           value,
  input  sitrt_pkg::cmd_t                 cmd,
  output sitrt_pkg::status_t              status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sitrt_pkg::CHAR_W-1:0]    out_char,
  output logic                            out_last
);
  import sitrt_pkg::*;

  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam int FW = $clog2(DIGIT_SLOTS + 1);
  localparam int CW = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    radix_sat_r;
  logic [RADIX_W-1:0]    radix_sat;
  logic [VALUE_BITS-1:0] mag_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic [FW-1:0]         fill_r;
  logic [FW-1:0]         fill_dec;
  logic [CHAR_W-1:0]     stack_mem [DIGIT_SLOTS];
  logic [CHAR_W-1:0]     rd_data_r;
  logic                  rd_last_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [RADIX_W:0]      rem_ext;
  logic [RADIX_W:0]      rdx_ext;
  logic [RADIX_W:0]      rem_diff;
  logic                  q_bit;
  logic                  push;
  logic                  room;
  logic [CHAR_W-1:0]     push_char;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wen) begin
      radix_r <= cfg_wdata;
    end
  end

  // out-of-range radix saturates to 2 or 36
  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix_r;
    end
  end

  // restoring division step: one quotient bit per cycle
  assign rem_ext  = {rem_r, mag_r[VALUE_BITS-1]};
  assign rdx_ext  = {1'b0, radix_sat_r};
  assign rem_diff = rem_ext - rdx_ext;
  assign q_bit    = (rem_ext >= rdx_ext);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r       <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      neg_r       <= value[VALUE_BITS-1];
      radix_sat_r <= radix_sat;
      rem_r       <= '0;
    end else if (cmd.div_step) begin
      mag_r <= {mag_r[VALUE_BITS-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[RADIX_W-1:0] : rem_ext[RADIX_W-1:0];
    end else if (cmd.push_digit) begin
      rem_r <= '0;
    end
  end

  // step counter within a digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load || cmd.push_digit) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // digit stack: push drops when full
  assign push      = cmd.push_digit || cmd.push_sign;
  assign room      = (fill_r < FW'(DIGIT_SLOTS));
  assign push_char = cmd.push_sign ? CHAR_MINUS : glyph(rem_r);
  assign fill_dec  = fill_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.load) begin
      fill_r <= '0;
    end else if (push && room) begin
      fill_r <= fill_r + 1'b1;
    end else if (cmd.pop_rd) begin
      fill_r <= fill_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (push && room) begin
      stack_mem[fill_r[AW-1:0]] <= push_char;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_rd) begin
      rd_data_r <= stack_mem[fill_dec[AW-1:0]];
      rd_last_r <= (fill_dec == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign status.div_done  = (cnt_r == CW'(VALUE_BITS - 1));
  assign status.mag_zero  = (mag_r == '0);
  assign status.neg       = neg_r;
  assign status.rd_last   = rd_last_r;
  assign status.slot_free = !out_valid_r || out_ready;
  assign status.fill_zero = (fill_r == '0);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for signed_integer_to_radix_text: streams signed integers,
// predicts the radix text per item and checks every character and tlast.
// Depends on sitrt_pkg and the signed_integer_to_radix_text RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam logic [36*8-1:0] GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [7:0] tdata;  // {pad, text_char}
    logic       tlast;  // last_char
  } char_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic [31:0]  pending_values [$];
  char_item_t   expected_chars [$];
  logic [5:0]   radix_reg = sitrt_pkg::RADIX_RESET;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         hold_go = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  err_cnt = 0;

  signed_integer_to_radix_text i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever begin
      #1 clk = ~clk;
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // register outside 2..36 saturates
  function automatic int unsigned eff_base(input logic [5:0] r);
    if (r < sitrt_pkg::RADIX_MIN) begin
      return sitrt_pkg::RADIX_MIN;
    end else if (r > sitrt_pkg::RADIX_MAX) begin
      return sitrt_pkg::RADIX_MAX;
    end
    return r;
  endfunction

  // digit stack: divide down the magnitude, then emit in reverse
  task automatic predict_text(input logic [31:0] v);
    logic [31:0]  mag;
    logic [6:0]   digits [$];
    int unsigned  base;
    int unsigned  d;
    char_item_t   item;
    base = eff_base(radix_reg);
    mag  = v[31] ? (~v + 32'd1) : v;
    if (mag == 0) begin
      digits = {digits, GLYPHS[8*35 +: 7]};
    end
    while (mag != 0) begin
      d = mag % base;
      digits = {digits, GLYPHS[8*(35-d) +: 7]};
      mag = mag / base;
    end
    if (v[31]) begin
      digits = {digits, sitrt_pkg::CHAR_MINUS};
    end
    while (digits.size() != 0) begin
      item.tdata = {1'b0, digits.pop_back()};
      item.tlast = (digits.size() == 0);
      expected_chars = {expected_chars, item};
    end
  endtask

  // value mix: full range, near zero, extremes, radix powers, short magnitudes
  function automatic logic [31:0] pick_value(input int unsigned base);
    logic [63:0] pw;
    logic [31:0] v;
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = 32'($urandom_range(0, 80)) - 32'd40;
      6: begin
        if ($urandom_range(0, 1) != 0) begin
          v = 32'h8000_0000 + 32'($urandom_range(0, 3));
        end else begin
          v = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
        end
      end
      7: begin
        pw = 64'd1;
        n  = $urandom_range(1, 31);
        repeat (n) begin
          if (pw * base <= 64'h7FFF_FFFF) begin
            pw = pw * base;
          end
        end
        v = pw[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1) != 0) begin
          v = ~v + 32'd1;
        end
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) != 0) begin
          v = ~v + 32'd1;
        end
      end
    endcase
    return v;
  endfunction

  // mirror of the radix register
  always @(posedge clk) begin
    if (!rst_n) begin
      radix_reg <= sitrt_pkg::RADIX_RESET;
    end else if (cfg_wen) begin
      radix_reg <= cfg_wdata;
    end
  end

  // driver: present queued values, predict on each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_values.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    char_item_t want;
    logic       bad;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          err_cnt <= err_cnt + 1;
          $display("%0t: unexpected item tdata=%h tlast=%b", $time, out_tdata, out_tlast);
        end else begin
          want = expected_chars.pop_front();
          bad  = 1'b0;
          if (out_tdata !== want.tdata) begin
            bad = 1'b1;
            $display("%0t: tdata mismatch expected=%h actual=%h", $time, want.tdata,
                     out_tdata);
          end
          if (out_tlast !== want.tlast) begin
            bad = 1'b1;
            $display("%0t: tlast mismatch expected=%b actual=%b", $time, want.tlast,
                     out_tlast);
          end
          // one count per item
          if (bad) begin
            err_cnt <= err_cnt + 1;
          end
        end
      end
      out_tready <= !(hold_go || hold_left != 0) &&
                    ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_radix(input logic [5:0] r);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // 0: none, 1: sender idles, 2: receiver stalls, 3: both lightly
  task automatic set_idle(input int unsigned mode);
    case (mode)
      1: begin send_idle_pct <= 71; recv_stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  recv_stall_pct <= 71; end
      3: begin send_idle_pct <= 18; recv_stall_pct <= 18; end
      default: begin send_idle_pct <= 0; recv_stall_pct <= 0; end
    endcase
  endtask

  // sender pauses until every expected character has come back;
  // checked on the falling edge, after the clocked updates have settled
  task automatic drain();
    while (pending_values.size() != 0 || in_tvalid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input logic [5:0] r, input int unsigned mode, input int n);
    write_radix(r);
    set_idle(mode);
    repeat (n) pending_values = {pending_values, pick_value(eff_base(r))};
    drain();
  endtask

  // stimulus
  initial begin
    logic [5:0] rand_radix [8];
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix (decimal): zero, all ones, both extremes
    pending_values = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       -32'sd1234567890};
    drain();

    // binary: the longest texts
    write_radix(6'd2);
    pending_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    drain();

    // radix 36: digits up to 'Z'
    write_radix(6'd36);
    pending_values = '{32'd35, 32'd36, -32'sd36, 32'h8000_0000, 32'h7FFF_FFFF};
    drain();

    // radix register below two saturates to binary
    write_radix(6'd0);
    pending_values = '{32'd5, -32'sd5};
    drain();
    write_radix(6'd1);
    pending_values = '{32'd3};
    drain();

    // radix register above thirty-six saturates to 36
    write_radix(6'd37);
    pending_values = '{32'd35, 32'd36};
    drain();
    write_radix(6'd63);
    pending_values = '{-32'sd1295, 32'd1295};
    drain();

    write_radix(6'd16);
    pending_values = '{32'hDEAD_BEEF};
    drain();

    // receiver holds off while the sender keeps offering
    write_radix(6'd36);
    set_idle(0);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (12) pending_values = {pending_values, pick_value(36)};
    drain();

    // random phases over radixes and idle patterns
    rand_radix = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd3, 6'd37, 6'd8, 6'd0};
    rand_radix[5] = 6'($urandom_range(37, 63));
    rand_radix[7] = 6'($urandom_range(0, 63));
    for (int i = 0; i < 8; i++) begin
      run_random(rand_radix[i], i % 4, 36);
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
